// File: rtl/lprd_pkg.sv
// Shared types and constants for the length-prefixed record deframer.
// No dependencies; imported by lprd_cfg_if, lprd_cfg_regs, lprd_parser and the top level.
package lprd_pkg;

    localparam int ID_BYTES = 16;

    localparam logic [31:0] MAGIC_RESET       = 32'h5A46_4E31;
    localparam logic [16:0] MAX_PAYLOAD_RESET = 17'd65536;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

    localparam logic [2:0] ROLE_MAGIC   = 3'd0;
    localparam logic [2:0] ROLE_ID      = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_DISCARD = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_ID    = 3'd1,
        PH_LEN   = 3'd2,
        PH_PAY   = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [16:0] max_payload_bytes;
    } lprd_cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  byte_role;
        logic [15:0] field_position;
        logic [15:0] record_number;
        logic [16:0] payload_length;
        logic        record_end;
        logic [1:0]  parse_status;
        logic        blob_end;
    } lprd_result_t;

endpackage

// File: rtl/lprd_in_if.sv
// Input byte channel: valid/ready handshake carrying one blob byte.
// Depends on nothing.
interface lprd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/lprd_out_if.sv
// Tagged byte channel: valid/ready handshake carrying one tagged result.
// Depends on nothing.
interface lprd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  byte_role;
    logic [15:0] field_position;
    logic [15:0] record_number;
    logic [16:0] payload_length;
    logic        record_end;
    logic [1:0]  parse_status;
    logic        blob_end;

    modport source (output valid, output out_byte, output byte_role, output field_position,
                    output record_number, output payload_length, output record_end,
                    output parse_status, output blob_end, input ready);
    modport sink   (input valid, input out_byte, input byte_role, input field_position,
                    input record_number, input payload_length, input record_end,
                    input parse_status, input blob_end, output ready);
endinterface

// File: rtl/lprd_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on lprd_pkg for widths.
interface lprd_cfg_if;
    import lprd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lprd_cfg_regs.sv
// Configuration registers: expected magic word and maximum payload length.
// Depends on lprd_pkg.
module lprd_cfg_regs
    import lprd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output lprd_cfg_t              cfg
);

    logic [31:0] magic_reg;
    logic [16:0] max_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= MAGIC_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (wr_en)
        begin
            // Unknown indexes are dropped.
            if (wr_index == CFG_MAGIC_WORD)
            begin
                magic_reg <= wr_data;
            end
            else if (wr_index == CFG_MAX_PAYLOAD)
            begin
                max_payload_reg <= wr_data[16:0];
            end
        end
    end

    assign cfg.magic_word        = magic_reg;
    assign cfg.max_payload_bytes = max_payload_reg;

endmodule

// File: rtl/lprd_parser.sv
// Parser state and per-byte tagging logic; state advances when a byte moves on.
// Depends on lprd_pkg.
module lprd_parser
    import lprd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  lprd_cfg_t    cfg,
    output lprd_result_t result
);

    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] rec_reg, rec_next;
    logic        mismatch_reg, mismatch_next;
    logic [1:0]  err_reg, err_next;

    logic [1:0]  pos_lo;
    logic [7:0]  expect_byte;
    logic        mismatch_now;
    logic [31:0] len_shift;
    logic [17:0] pos_inc;
    logic        id_done;
    logic        pay_done;
    logic        len_too_long;
    logic [15:0] pos_sat16;
    logic [15:0] rec_bump;

    logic [2:0]  role;
    logic [15:0] fpos;
    logic [16:0] plen;
    logic        rend;
    logic        clean_end;

    assign pos_lo = pos_reg[1:0];

    always_comb
    begin
        case (pos_lo)
            2'd0:    expect_byte = cfg.magic_word[31:24];
            2'd1:    expect_byte = cfg.magic_word[23:16];
            2'd2:    expect_byte = cfg.magic_word[15:8];
            default: expect_byte = cfg.magic_word[7:0];
        endcase
    end

    assign mismatch_now = mismatch_reg | (data_byte != expect_byte);
    assign len_shift    = {len_reg[23:0], data_byte};
    assign pos_inc      = {1'b0, pos_reg} + 18'd1;
    assign id_done      = pos_inc >= 18'(ID_BYTES);
    assign pay_done     = {15'd0, pos_inc} >= {1'b0, len_reg};
    assign len_too_long = len_shift > {15'd0, cfg.max_payload_bytes};
    assign pos_sat16    = pos_reg[16] ? 16'hFFFF : pos_reg[15:0];
    assign rec_bump     = (rec_reg == 16'hFFFF) ? rec_reg : rec_reg + 16'd1;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_MAGIC:
            begin
                if (pos_lo == 2'd3)
                begin
                    phase_next = mismatch_now ? PH_ERR : PH_ID;
                end
            end
            PH_ID:
            begin
                if (id_done)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (pos_lo == 2'd3)
                begin
                    if (len_too_long)
                    begin
                        phase_next = PH_ERR;
                    end
                    else if (len_shift == 32'd0)
                    begin
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                if (pay_done)
                begin
                    phase_next = PH_ID;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    // Counters, tags and sticky error.
    always_comb
    begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        rec_next      = rec_reg;
        mismatch_next = mismatch_reg;
        err_next      = err_reg;
        role          = ROLE_DISCARD;
        fpos          = 16'd0;
        plen          = 17'd0;
        rend          = 1'b0;
        case (phase_reg)
            PH_MAGIC:
            begin
                role          = ROLE_MAGIC;
                fpos          = {14'd0, pos_lo};
                mismatch_next = mismatch_now;
                if (pos_lo == 2'd3)
                begin
                    pos_next = 17'd0;
                    if (mismatch_now)
                    begin
                        err_next = ST_BAD_MAGIC;
                    end
                end
                else
                begin
                    pos_next = {15'd0, pos_lo} + 17'd1;
                end
            end
            PH_ID:
            begin
                role = ROLE_ID;
                fpos = pos_sat16;
                if (id_done)
                begin
                    pos_next = 17'd0;
                    len_next = 32'd0;
                end
                else
                begin
                    pos_next = pos_inc[16:0];
                end
            end
            PH_LEN:
            begin
                role     = ROLE_LENGTH;
                fpos     = {14'd0, pos_lo};
                len_next = len_shift;
                if (pos_lo == 2'd3)
                begin
                    pos_next = 17'd0;
                    plen     = (|len_shift[31:17]) ? 17'h1FFFF : len_shift[16:0];
                    if (len_too_long)
                    begin
                        err_next = ST_TOO_LONG;
                    end
                    else if (len_shift == 32'd0)
                    begin
                        rend     = 1'b1;
                        rec_next = rec_bump;
                    end
                end
                else
                begin
                    pos_next = {15'd0, pos_lo} + 17'd1;
                end
            end
            PH_PAY:
            begin
                role = ROLE_PAYLOAD;
                fpos = pos_sat16;
                plen = (|len_reg[31:17]) ? 17'h1FFFF : len_reg[16:0];
                if (pay_done)
                begin
                    rend     = 1'b1;
                    rec_next = rec_bump;
                    pos_next = 17'd0;
                end
                else
                begin
                    pos_next = pos_inc[16:0];
                end
            end
            default: role = ROLE_DISCARD;
        endcase
    end

    assign clean_end = (phase_next == PH_MAGIC) ||
                       ((phase_next == PH_ID) && (pos_next == 17'd0));

    always_comb
    begin
        result.out_byte       = data_byte;
        result.byte_role      = role;
        result.field_position = fpos;
        result.record_number  = rec_reg;
        result.payload_length = plen;
        result.record_end     = rend;
        result.blob_end       = last_byte;
        result.parse_status   = err_reg;
        if (last_byte && (err_next == ST_OK) && !clean_end)
        begin
            result.parse_status = ST_TRUNC;
        end
        else
        begin
            result.parse_status = err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            pos_reg      <= 17'd0;
            len_reg      <= 32'd0;
            rec_reg      <= 16'd0;
            mismatch_reg <= 1'b0;
            err_reg      <= ST_OK;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                // Blob done: start over for the next one.
                phase_reg    <= PH_MAGIC;
                pos_reg      <= 17'd0;
                len_reg      <= 32'd0;
                rec_reg      <= 16'd0;
                mismatch_reg <= 1'b0;
                err_reg      <= ST_OK;
            end
            else
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                len_reg      <= len_next;
                rec_reg      <= rec_next;
                mismatch_reg <= mismatch_next;
                err_reg      <= err_next;
            end
        end
    end

endmodule

// File: rtl/length_prefixed_record_deframer_unit.sv
// Length-prefixed record deframer, top level: input register, parser, result register.
// Depends on lprd_pkg, the three channel interfaces, lprd_cfg_regs and lprd_parser.
//
// Usage:
//   blob   - byte request channel (data_byte, last_byte). last_byte marks the end of a blob.
//   tags   - one result request per input byte: the byte with its role, field offset,
//            record number, declared length, record_end, parse_status and blob_end.
//            parse_status is final on the result that carries blob_end.
//   cfg    - register writes: index 0 magic word, index 1 max payload length.
//            Always ready; write only while no byte is in flight.
// A result passes through the input register and then the result register before it can
// leave on tags. One byte per cycle is sustained while tags is ready; the parser state
// updates as each byte moves from the input register into the result register.
// Reset clears the parser to the magic phase, empties both registers and loads the
// default magic word and maximum length. After each last byte the parser returns to
// the same state on its own.
// When tags stalls, the result register holds and the input register keeps one
// more byte; blob.ready drops only when both are full.
module length_prefixed_record_deframer_unit
    import lprd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lprd_in_if.sink    blob,
    lprd_out_if.source tags,
    lprd_cfg_if.sink   cfg
);

    lprd_cfg_t    cfg_val;
    lprd_result_t result;
    lprd_result_t result_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;

    logic out_free;
    logic advance;
    logic take;

    assign out_free = !out_valid_reg || tags.ready;
    assign advance  = in_valid_reg && out_free;
    assign take     = blob.valid && blob.ready;

    assign blob.ready = !in_valid_reg || out_free;
    assign cfg.ready  = 1'b1;

    lprd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    lprd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg_val),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tags.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= blob.data_byte;
            in_last_reg <= blob.last_byte;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign tags.valid          = out_valid_reg;
    assign tags.out_byte       = result_reg.out_byte;
    assign tags.byte_role      = result_reg.byte_role;
    assign tags.field_position = result_reg.field_position;
    assign tags.record_number  = result_reg.record_number;
    assign tags.payload_length = result_reg.payload_length;
    assign tags.record_end     = result_reg.record_end;
    assign tags.parse_status   = result_reg.parse_status;
    assign tags.blob_end       = result_reg.blob_end;

endmodule
